// ===== rtl/core/lpm_pkg.sv =====
// Shared types and constants of the longest prefix match routing table.
`default_nettype none

package lpm_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int INDEX_WIDTH = 6;
   localparam int PORT_COUNT = 4;
   localparam int PORT_WIDTH = 2;
   localparam int ADDR_WIDTH = 32;

   // Cycles from an accepted lookup to its result strobe.
   localparam int LOOKUP_LATENCY = TABLE_DEPTH + 2;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef struct packed {
      logic                  cmd;
      logic [INDEX_WIDTH-1:0] entry_index;
      logic [ADDR_WIDTH-1:0]  entry_dest;
      logic [ADDR_WIDTH-1:0]  entry_mask;
      logic [ADDR_WIDTH-1:0]  entry_gateway;
      logic [PORT_WIDTH-1:0]  entry_port;
      logic                  entry_valid;
      logic [ADDR_WIDTH-1:0]  lookup_address;
   } lpm_req_type;

   typedef struct packed {
      logic                  hit;
      logic [INDEX_WIDTH-1:0] match_index;
      logic [ADDR_WIDTH-1:0]  match_gateway;
      logic [PORT_WIDTH-1:0]  match_port;
      logic [ADDR_WIDTH-1:0]  match_mask;
   } lpm_rsp_type;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0] dest;
      logic [ADDR_WIDTH-1:0] mask;
      logic [ADDR_WIDTH-1:0] gateway;
      logic [PORT_WIDTH-1:0] port;
   } route_entry_type;

   localparam int ENTRY_WIDTH = $bits(route_entry_type);

endpackage

`default_nettype wire

// ===== rtl/core/lpm_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module lpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic                                       rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/longest_prefix_match_table_core.sv =====
// Top level of the longest prefix match routing table: entry RAM and scan engine.
// A write beat does not raise busy, so the block is ready again in the next cycle.
// A lookup reads one slot a cycle, so its result is registered only after the scan
// has stepped through all 64 reads, the registered RAM read and the result state.
// Busy falls with the result, so the next beat may be accepted while it is shown.
// Synchronous reset clears the valid bits and all control state; entry data is not cleared.
`default_nettype none

module longest_prefix_match_table_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output      logic                 busy,
   input  wire lpm_pkg::lpm_req_type req_data,
   output      logic                 rsp_valid,
   output      lpm_pkg::lpm_rsp_type rsp_data
);

   import lpm_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   state_type state_ff;

   logic [TABLE_DEPTH-1:0]  valid_ff;
   logic [INDEX_WIDTH-1:0]  scan_addr_ff;
   logic [ADDR_WIDTH-1:0]   address_ff;

   // Pipeline stage that lines up with the registered RAM read data.
   logic                    pend_live_ff;
   logic                    pend_valid_ff;
   logic [INDEX_WIDTH-1:0]  pend_slot_ff;

   logic                    best_found_ff;
   logic [INDEX_WIDTH-1:0]  best_slot_ff;
   logic [ADDR_WIDTH-1:0]   best_mask_ff;
   logic [ADDR_WIDTH-1:0]   best_gateway_ff;
   logic [PORT_WIDTH-1:0]   best_port_ff;

   logic                    best_found_in;
   logic [INDEX_WIDTH-1:0]  best_slot_in;
   logic [ADDR_WIDTH-1:0]   best_mask_in;
   logic [ADDR_WIDTH-1:0]   best_gateway_in;
   logic [PORT_WIDTH-1:0]   best_port_in;

   logic                    rsp_valid_ff;
   lpm_rsp_type             rsp_ff;

   logic                    accept;
   logic                    wr_en;
   logic                    rd_en;
   logic                    entry_match;
   logic                    take;
   logic [ENTRY_WIDTH-1:0]  rd_data;
   route_entry_type         entry;
   route_entry_type         wr_entry;

   localparam logic [INDEX_WIDTH:0] DEPTH_LIMIT = (INDEX_WIDTH + 1)'(TABLE_DEPTH);
   localparam logic [INDEX_WIDTH-1:0] LAST_SLOT = INDEX_WIDTH'(TABLE_DEPTH - 1);

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign wr_en  = accept && (req_data.cmd == CMD_WRITE)
                   && ({1'b0, req_data.entry_index} < DEPTH_LIMIT);
   assign rd_en  = (state_ff == ST_SCAN);

   always_comb begin
      wr_entry.dest    = req_data.entry_dest;
      wr_entry.mask    = req_data.entry_mask;
      wr_entry.gateway = req_data.entry_gateway;
      wr_entry.port    = req_data.entry_port;
   end

   lpm_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_data.entry_index),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (scan_addr_ff),
      .rd_data (rd_data)
   );

   assign entry = route_entry_type'(rd_data);

   // A strictly greater mask is needed to replace the current best, so the
   // earliest slot wins among equal masks.
   assign entry_match = pend_live_ff && pend_valid_ff
                        && (((entry.dest ^ address_ff) & entry.mask) == '0);
   assign take = entry_match && (!best_found_ff || (entry.mask > best_mask_ff));

   always_comb begin
      best_found_in   = best_found_ff;
      best_slot_in    = best_slot_ff;
      best_mask_in    = best_mask_ff;
      best_gateway_in = best_gateway_ff;
      best_port_in    = best_port_ff;
      if (take) begin
         best_found_in   = 1'b1;
         best_slot_in    = pend_slot_ff;
         best_mask_in    = entry.mask;
         best_gateway_in = entry.gateway;
         best_port_in    = entry.port;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         scan_addr_ff  <= '0;
         pend_live_ff  <= 1'b0;
         best_found_ff <= 1'b0;
         best_slot_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         pend_live_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (wr_en) begin
                  valid_ff[req_data.entry_index] <= req_data.entry_valid;
               end
               if (accept && (req_data.cmd == CMD_LOOKUP)) begin
                  state_ff      <= ST_SCAN;
                  scan_addr_ff  <= '0;
                  address_ff    <= req_data.lookup_address;
                  best_found_ff <= 1'b0;
                  best_slot_ff  <= '0;
               end
            end
            ST_SCAN: begin
               pend_live_ff  <= 1'b1;
               pend_valid_ff <= valid_ff[scan_addr_ff];
               pend_slot_ff  <= scan_addr_ff;
               best_found_ff   <= best_found_in;
               best_slot_ff    <= best_slot_in;
               best_mask_ff    <= best_mask_in;
               best_gateway_ff <= best_gateway_in;
               best_port_ff    <= best_port_in;
               if (scan_addr_ff == LAST_SLOT) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  scan_addr_ff <= scan_addr_ff + INDEX_WIDTH'(1);
               end
            end
            ST_DRAIN: begin
               best_found_ff   <= best_found_in;
               best_slot_ff    <= best_slot_in;
               best_mask_ff    <= best_mask_in;
               best_gateway_ff <= best_gateway_in;
               best_port_ff    <= best_port_in;
               rsp_valid_ff    <= 1'b1;
               state_ff        <= ST_IDLE;
               if (best_found_in) begin
                  rsp_ff.hit           <= 1'b1;
                  rsp_ff.match_index   <= best_slot_in;
                  rsp_ff.match_gateway <= best_gateway_in;
                  rsp_ff.match_port    <= best_port_in;
                  rsp_ff.match_mask    <= best_mask_in;
               end else begin
                  rsp_ff <= '0;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lpm_checker.sv =====
// Port-level assertions for the longest prefix match table, bound to the top level.
`default_nettype none

module lpm_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 start,
   input wire logic                 busy,
   input wire lpm_pkg::lpm_req_type req_data,
   input wire logic                 rsp_valid,
   input wire lpm_pkg::lpm_rsp_type rsp_data
);

   import lpm_pkg::*;

   // A lookup beat always yields its result after the full scan.
   a_lookup_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.cmd == CMD_LOOKUP)) |-> ##LOOKUP_LATENCY rsp_valid)
      else $error("lookup result did not arrive after the scan");

   // A lookup holds the block busy, a write does not.
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.cmd == CMD_LOOKUP)) |=> busy)
      else $error("block not busy after a lookup beat");

   a_write_ready: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.cmd == CMD_WRITE)) |=> !busy)
      else $error("block busy after a write beat");

   // A result is only shown once the scan has finished.
   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while a scan is running");

   // A miss reports every field as zero.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.hit) |-> ((rsp_data.match_index == '0)
                                        && (rsp_data.match_gateway == '0)
                                        && (rsp_data.match_port == '0)
                                        && (rsp_data.match_mask == '0)))
      else $error("miss result carries non-zero fields");

endmodule

bind longest_prefix_match_table_core lpm_checker u_lpm_checker (.*);

`default_nettype wire
